@@ rtl/pmu_pkg.sv @@
// Package with types, constants and Q16.16 helper functions for the particle motion update.
package pmu_pkg;

  localparam int CURVE_BINS = 64;
  localparam int BIN_W      = $clog2(CURVE_BINS);
  localparam int CURVE_W    = 128;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_CURVE  = 2'd1,
    CMD_END    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PART = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_MAX  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_DT    = 3'd0,
    REG_WX    = 3'd1,
    REG_WY    = 3'd2,
    REG_WZ    = 3'd3,
    REG_GRAV  = 3'd4
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_OUT,
    ST_BMIN,
    ST_BMAX
  } state_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'(Q_MAX)) return Q_MAX;
    else if (v < 64'(Q_MIN)) return Q_MIN;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> 16);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat64(64'(a) + 64'(b));
  endfunction

endpackage

@@ rtl/pmu_ram.sv @@
// Generic single-port-write RAM with registered read.
module pmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/particle_motion_update.sv @@
// Top level of the particle motion update block.
// Words enter on the in_ stream (cmd, particle state, curve bin) and leave on the out_
// stream. The five registers (time step, wind x/y/z, gravity) are set through cfg_; the
// user must write them only while the block is idle, as the block does not enforce it.
// A curve write word stores four Q16.16 curve values into one bin of the curve RAM in
// the cycle it is accepted, and the next word can be accepted in the cycle after.
// An update word runs the age and lifetime check on the input word, reads its curve bin
// at the accepting edge, then passes three registered multiply stages and a bounding box
// stage, and ST_OUT loads its result into the output register. Dead particles, unknown
// commands and an end of batch with an empty box produce no output word, and the block
// stays idle. An end of batch word with a live particle seen since the previous end of
// batch emits the box minimum from ST_BMIN and, once the minimum has been taken, the box
// maximum from ST_BMAX. One word is in work at a time. The result is held in an output
// register until the receiver takes it; while out_tvalid is high, in_tready stays low, so
// a receiver stall holds back the next input word. After reset the box is empty, the
// registers are zero and the curve RAM holds unknown contents until written.
module particle_motion_update (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_angle, age_time,
  // inv_max_life, spin_variation, curve_bin, zero fill
  input  logic [335:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // kind, out_pos_x/y/z, out_vel_x/y/z, out_acc_x/y/z, out_spin, out_age, zero fill
  output logic [359:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import pmu_pkg::*;

  logic signed [31:0] dt_r, wx_r, wy_r, wz_r, grav_r;
  state_t state_r, state_nxt;

  logic [1:0] i_cmd;
  logic signed [31:0] i_px, i_py, i_pz, i_vx, i_vy, i_vz, i_spin, i_age, i_sv;
  logic [30:0] i_inv;
  logic [5:0] i_bin;
  assign i_cmd  = in_tdata[1:0];
  assign i_px   = in_tdata[33:2];
  assign i_py   = in_tdata[65:34];
  assign i_pz   = in_tdata[97:66];
  assign i_vx   = in_tdata[129:98];
  assign i_vy   = in_tdata[161:130];
  assign i_vz   = in_tdata[193:162];
  assign i_spin = in_tdata[225:194];
  assign i_age  = in_tdata[257:226];
  assign i_inv  = in_tdata[288:258];
  assign i_sv   = in_tdata[320:289];
  assign i_bin  = in_tdata[326:321];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= '0; wx_r <= '0; wy_r <= '0; wz_r <= '0; grav_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DT:   dt_r   <= cfg_wdata;
        REG_WX:   wx_r   <= cfg_wdata;
        REG_WY:   wy_r   <= cfg_wdata;
        REG_WZ:   wz_r   <= cfg_wdata;
        REG_GRAV: grav_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = in_tvalid && in_tready;

  // Age and alive test on the input word.
  logic signed [31:0] abs_dt, age_new;
  logic signed [63:0] rel_prod;
  logic alive;
  logic [BIN_W-1:0] rd_bin;
  logic [15:0] rel;
  assign abs_dt   = dt_r[31] ? ((dt_r == Q_MIN) ? Q_MAX : -dt_r) : dt_r;
  assign age_new  = qadd(i_age, abs_dt);
  assign rel_prod = 64'(age_new) * $signed({33'd0, i_inv});
  assign alive    = !rel_prod[63] && (rel_prod[63:32] == '0);
  assign rel      = rel_prod[31:16];
  assign rd_bin   = BIN_W'((32'(rel) * CURVE_BINS) >> 16);

  logic ram_we;
  logic [CURVE_W-1:0] ram_rdata;
  assign ram_we = accept && (i_cmd == CMD_CURVE) && (32'(i_bin) < CURVE_BINS);

  pmu_ram #(.WIDTH(CURVE_W), .DEPTH(CURVE_BINS)) u_curve (
    .clk   (clk),
    .we    (ram_we),
    .waddr (BIN_W'(i_bin)),
    .wdata ({i_spin, i_vz, i_vy, i_vx}),
    .raddr (rd_bin),
    .rdata (ram_rdata)
  );

  // Particle payload registers.
  logic signed [31:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r, sp_r, sv_r, age_r;
  logic signed [31:0] ax_r, ay_r, az_r, st_r, rs_r, mass_r;
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic seen_r;
  logic [359:0] odata_r;
  logic ovalid_r;

  logic signed [31:0] c_air, c_mass, c_vf, c_rv;
  assign c_air  = ram_rdata[31:0];
  assign c_mass = ram_rdata[63:32];
  assign c_vf   = ram_rdata[95:64];
  assign c_rv   = ram_rdata[127:96];

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = !ovalid_r;
        if (in_tvalid && !ovalid_r) begin
          priority if (i_cmd == CMD_UPDATE && alive) state_nxt = ST_READ;
          else if (i_cmd == CMD_END && seen_r)   state_nxt = ST_BMIN;
          else state_nxt = ST_IDLE;
        end
      end
      ST_READ: state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      ST_BMIN: if (!ovalid_r) state_nxt = ST_BMAX;
      ST_BMAX: if (!ovalid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  logic signed [31:0] npx, npy, npz;
  assign npx = qadd(px_r, qmul(vx_r, st_r));
  assign npy = qadd(py_r, qmul(vy_r, st_r));
  assign npz = qadd(pz_r, qmul(vz_r, st_r));

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (accept) begin
        px_r <= i_px; py_r <= i_py; pz_r <= i_pz;
        vx_r <= i_vx; vy_r <= i_vy; vz_r <= i_vz;
        sp_r <= i_spin; sv_r <= i_sv; age_r <= age_new;
      end
      ST_READ: begin
        ax_r   <= qmul(wx_r, c_air);
        ay_r   <= qadd(qmul(wy_r, c_air), grav_r);
        az_r   <= qmul(wz_r, c_air);
        st_r   <= qmul(dt_r, c_vf);
        rs_r   <= qmul(c_rv, sv_r);
        mass_r <= c_mass;
      end
      ST_M1: begin
        ax_r <= qmul(ax_r, mass_r);
        ay_r <= qmul(ay_r, mass_r);
        az_r <= qmul(az_r, mass_r);
        px_r <= npx; py_r <= npy; pz_r <= npz;
        rs_r <= qmul(rs_r, dt_r);
      end
      ST_M2: begin
        vx_r <= qadd(vx_r, qmul(ax_r, dt_r));
        vy_r <= qadd(vy_r, qmul(ay_r, dt_r));
        vz_r <= qadd(vz_r, qmul(az_r, dt_r));
        sp_r <= qadd(sp_r, rs_r);
      end
      default: ;
    endcase
  end

  // Position step uses st_r computed in ST_READ; px_r is updated in ST_M1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        ST_M3: begin
          if (!seen_r) begin
            lo_r[0] <= px_r; lo_r[1] <= py_r; lo_r[2] <= pz_r;
            hi_r[0] <= px_r; hi_r[1] <= py_r; hi_r[2] <= pz_r;
          end else begin
            if (px_r < lo_r[0]) lo_r[0] <= px_r;
            if (py_r < lo_r[1]) lo_r[1] <= py_r;
            if (pz_r < lo_r[2]) lo_r[2] <= pz_r;
            if (px_r > hi_r[0]) hi_r[0] <= px_r;
            if (py_r > hi_r[1]) hi_r[1] <= py_r;
            if (pz_r > hi_r[2]) hi_r[2] <= pz_r;
          end
          seen_r <= 1'b1;
        end
        ST_OUT: begin
          ovalid_r <= 1'b1;
          odata_r  <= {6'd0, age_r, sp_r, az_r, ay_r, ax_r, vz_r, vy_r, vx_r,
                       pz_r, py_r, px_r, KIND_PART};
        end
        ST_BMIN: if (!ovalid_r) begin
          ovalid_r <= 1'b1;
          odata_r  <= {262'd0, lo_r[2], lo_r[1], lo_r[0], KIND_MIN};
        end
        ST_BMAX: if (!ovalid_r) begin
          ovalid_r <= 1'b1;
          odata_r  <= {262'd0, hi_r[2], hi_r[1], hi_r[0], KIND_MAX};
          seen_r   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule

@@ rtl/pmu_checker.sv @@
// Port-level checker for the particle motion update block, with its bind.
module pmu_port_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [359:0] out_tdata
);
  import pmu_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == KIND_PART || out_tdata[1:0] == KIND_MIN ||
                    out_tdata[1:0] == KIND_MAX))
    else $error("bad result kind");

  a_max_after_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[1:0] == KIND_MIN |=> !in_tready)
    else $error("input taken between box minimum and maximum");

  a_no_in_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");
endmodule

bind particle_motion_update pmu_port_checker u_pmu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
